[hw/rtl/ilse_pkg.sv]
`default_nettype none

package ilse_pkg;

	// list geometry
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	// derived widths
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int INDEX_W = 8;
	localparam int POS_W   = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 2;

	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_READ   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_DELETE = 3'd4,
		CMD_POP    = 3'd5,
		CMD_PEEK   = 3'd6,
		CMD_CLEAR  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/ilse_ram.sv]
`default_nettype none

module ilse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/indexed_list_stack_engine.sv]
`default_nettype none

// indexed list / stack engine: an ordered list of up to DEPTH elements held in one
// single-port-write, registered-read RAM, with a register holding the element count.
// One request carries a command (push, read, write, insert, delete, pop, peek, clear),
// an index (negative values count from the end, position = count + index + 1) and a
// data word; every request yields exactly one response with read data, the new count,
// a status (ok, bad index, empty, full) and a top-valid flag for pop. Push, write,
// clear, delete of the last element, insert at the end, pop of the only element and
// every rejected request load the response on acceptance; read, peek and any other
// pop first read the RAM and respond from the finish state;
// insert and delete at other positions pass through a shift state, which moves one
// element per cycle through the RAM's single write port, and then the finish state.
// A new request is taken only after the previous one has finished, and while the
// response register is free or being drained.
module indexed_list_stack_engine
	import ilse_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// request channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [2:0]            cmd,
	input  wire logic signed [INDEX_W-1:0] index,
	input  wire logic [DATA_WIDTH-1:0] data_in,

	// response channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      data_out,
	output logic [CNT_W-1:0]           count,
	output logic [1:0]                 status,
	output logic                       top_valid
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SHIFT = 3'b010,
		S_FIN   = 3'b100
	} state_t;

	state_t state_q, state_d;

	// list state
	logic [CNT_W-1:0] count_q, cnt_d;

	// command context kept across the shift and finish cycles
	logic [AW-1:0]         ptr_q, ptr_d;      // address of the read in flight
	logic [AW-1:0]         end_q, end_d;      // last address to move (insert: target position)
	logic                  ins_q;             // shift direction: toward higher addresses
	logic [DATA_WIDTH-1:0] data_q;
	logic                  fin_wr_q;          // finish writes data_q at end_q
	logic                  fin_rd_q;          // finish returns the RAM read data
	logic                  fin_topv_q;
	logic [CNT_W-1:0]      fin_cnt_q, fin_cnt_d;

	// response register
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic [CNT_W-1:0]      count_out_q;
	status_t               status_out_q;
	logic                  top_valid_q;

	// RAM port signals
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	// response load
	logic                  res_load;
	logic [DATA_WIDTH-1:0] res_data;
	logic [CNT_W-1:0]      res_cnt;
	status_t               res_st;
	logic                  res_topv;

	logic out_free, accept;
	cmd_t cmd_c;

	// position decode
	logic signed [POS_W-1:0] idx_ext, cnt_ext, pos;
	logic                    pos_lt_cnt, pos_le_cnt, pos_eq_cnt;
	logic [AW-1:0]           pos_a, count_a, cnt_m1_a, cnt_m2_a;
	logic                    is_full, is_empty;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign cmd_c    = cmd_t'(cmd);

	assign idx_ext = {{(POS_W-INDEX_W){index[INDEX_W-1]}}, index};
	assign cnt_ext = {{(POS_W-CNT_W){1'b0}}, count_q};
	// negative index counts from the end
	assign pos = index[INDEX_W-1] ? (cnt_ext + idx_ext + POS_W'(1)) : idx_ext;

	assign pos_lt_cnt = !pos[POS_W-1] && (pos < cnt_ext);
	assign pos_le_cnt = !pos[POS_W-1] && (pos <= cnt_ext);
	assign pos_eq_cnt = !pos[POS_W-1] && (pos == cnt_ext);
	assign pos_a      = pos[AW-1:0];

	assign count_a  = count_q[AW-1:0];
	assign cnt_m1_a = AW'(count_q - CNT_W'(1));
	assign cnt_m2_a = AW'(count_q - CNT_W'(2));
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		state_d   = state_q;
		cnt_d     = count_q;
		ptr_d     = ptr_q;
		end_d     = end_q;
		fin_cnt_d = fin_cnt_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = data_in;
		ram_re    = 1'b0;
		ram_raddr = '0;
		res_load  = 1'b0;
		res_data  = '0;
		res_cnt   = count_q;
		res_st    = ST_OK;
		res_topv  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_c)
						CMD_PUSH: begin
							res_load = 1'b1;
							if (is_full) begin
								res_st = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_a;
								cnt_d     = count_q + CNT_W'(1);
								res_cnt   = cnt_d;
							end
						end
						CMD_READ: begin
							if (!pos_lt_cnt) begin
								res_load = 1'b1;
								res_st   = ST_RANGE;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = pos_a;
								fin_cnt_d = count_q;
								state_d   = S_FIN;
							end
						end
						CMD_WRITE: begin
							res_load = 1'b1;
							if (!pos_lt_cnt) begin
								res_st = ST_RANGE;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = pos_a;
							end
						end
						CMD_INSERT: begin
							if (!pos_le_cnt) begin
								res_load = 1'b1;
								res_st   = ST_RANGE;
							end else if (is_full) begin
								res_load = 1'b1;
								res_st   = ST_FULL;
							end else if (pos_eq_cnt) begin
								// insert at the end is a plain append
								res_load  = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = pos_a;
								cnt_d     = count_q + CNT_W'(1);
								res_cnt   = cnt_d;
							end else begin
								// move the tail up, starting from the last element
								ram_re    = 1'b1;
								ram_raddr = cnt_m1_a;
								ptr_d     = cnt_m1_a;
								end_d     = pos_a;
								fin_cnt_d = count_q + CNT_W'(1);
								state_d   = S_SHIFT;
							end
						end
						CMD_DELETE: begin
							if (!pos_lt_cnt) begin
								res_load = 1'b1;
								res_st   = ST_RANGE;
							end else if (pos_a == cnt_m1_a) begin
								res_load = 1'b1;
								cnt_d    = count_q - CNT_W'(1);
								res_cnt  = cnt_d;
							end else begin
								// move the tail down, starting just above the hole
								ram_re    = 1'b1;
								ram_raddr = pos_a + AW'(1);
								ptr_d     = pos_a + AW'(1);
								end_d     = cnt_m1_a;
								fin_cnt_d = count_q - CNT_W'(1);
								state_d   = S_SHIFT;
							end
						end
						CMD_POP: begin
							if (is_empty) begin
								res_load = 1'b1;
								res_st   = ST_EMPTY;
							end else if (count_q == CNT_W'(1)) begin
								// last element popped: no new top
								res_load = 1'b1;
								cnt_d    = '0;
								res_cnt  = '0;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = cnt_m2_a;
								fin_cnt_d = count_q - CNT_W'(1);
								state_d   = S_FIN;
							end
						end
						CMD_PEEK: begin
							if (is_empty) begin
								res_load = 1'b1;
								res_st   = ST_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = cnt_m1_a;
								fin_cnt_d = count_q;
								state_d   = S_FIN;
							end
						end
						CMD_CLEAR: begin
							res_load = 1'b1;
							cnt_d    = '0;
							res_cnt  = '0;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end

			S_SHIFT: begin
				// write back the element read last cycle, one place over
				ram_we    = 1'b1;
				ram_waddr = ins_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
				ram_wdata = ram_rdata;
				if (ptr_q == end_q) begin
					state_d = S_FIN;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ins_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
					ptr_d     = ram_raddr;
				end
			end

			S_FIN: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_cnt   = fin_cnt_q;
					res_data  = fin_rd_q ? ram_rdata : '0;
					res_topv  = fin_topv_q;
					cnt_d     = fin_cnt_q;
					ram_we    = fin_wr_q;
					ram_waddr = end_q;
					ram_wdata = data_q;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command context and response payload
	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		end_q     <= end_d;
		fin_cnt_q <= fin_cnt_d;
		if (accept) begin
			data_q     <= data_in;
			ins_q      <= (cmd_c == CMD_INSERT);
			fin_wr_q   <= (cmd_c == CMD_INSERT);
			fin_rd_q   <= (cmd_c == CMD_READ) || (cmd_c == CMD_PEEK) || (cmd_c == CMD_POP);
			fin_topv_q <= (cmd_c == CMD_POP);
		end
		if (res_load) begin
			data_out_q   <= res_data;
			count_out_q  <= res_cnt;
			status_out_q <= res_st;
			top_valid_q  <= res_topv;
		end
	end

	ilse_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign count     = count_out_q;
	assign status    = status_out_q;
	assign top_valid = top_valid_q;

endmodule

`default_nettype wire

[hw/rtl/ilse_chk.sv]
`default_nettype none

module ilse_chk
	import ilse_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [DATA_WIDTH-1:0]     data_out,
	input wire logic [CNT_W-1:0]          count,
	input wire logic [1:0]                status,
	input wire logic                      top_valid
);

	// a blocked response must keep new requests out
	a_no_accept_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while response blocked");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CNT_W'(DEPTH))
		else $error("count beyond capacity");

	a_top_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && top_valid |-> status == ST_OK && count != '0)
		else $error("top valid on failed pop or empty list");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count == '0 && data_out == '0)
		else $error("empty status with nonzero count or data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(count))
		else $error("stalled response changed");

endmodule

bind indexed_list_stack_engine ilse_chk u_chk (.*);

`default_nettype wire
